>>> hdl/dtet_pkg.sv
// Shared constants and types for the due timer event table.
`timescale 1ns / 1ps
package dtet_pkg;

  localparam int EVENT_SLOTS = 16;
  localparam int SLOT_IW     = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int CNT_W       = $clog2(EVENT_SLOTS + 1);

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_CHECK = 2'd2;

  localparam logic KIND_FIRED  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [31:0] stamp;
    logic [7:0]  schedule;
    logic [7:0]  portion;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic write;
    logic clear;
    logic start;
    logic want_due;
    logic scan;
    logic fire;
    logic report;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic out_free;
  } status_t;

endpackage

>>> hdl/dtet_in_if.sv
// Request channel carrying write, clear and check items into the event table.
`timescale 1ns / 1ps
interface dtet_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  slot;
  logic [31:0] in_timestamp;
  logic [7:0]  in_schedule;
  logic [7:0]  in_portion;
  logic [31:0] now_time;

  modport source (
    output valid, mode, slot, in_timestamp, in_schedule, in_portion, now_time,
    input  ready
  );
  modport sink (
    input  valid, mode, slot, in_timestamp, in_schedule, in_portion, now_time,
    output ready
  );
endinterface

>>> hdl/dtet_out_if.sv
// Result channel carrying fired events and next alarm reports.
`timescale 1ns / 1ps
interface dtet_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_schedule;
  logic [7:0]  out_portion;
  logic [31:0] out_timestamp;
  logic        alarm_set;
  logic        last;

  modport source (
    output valid, kind, out_schedule, out_portion, out_timestamp, alarm_set, last,
    input  ready
  );
  modport sink (
    input  valid, kind, out_schedule, out_portion, out_timestamp, alarm_set, last,
    output ready
  );
endinterface

>>> hdl/dtet_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dtet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/dtet_ctrl.sv
// Controller state machine sequencing the scans of the event table.
`timescale 1ns / 1ps
module dtet_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_mode,
  output logic             in_ready,
  input  dtet_pkg::status_t status,
  output dtet_pkg::cmd_t    cmd
);
  import dtet_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   pass_due_r, pass_due_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    pass_due_nxt = pass_due_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_mode)
            MODE_WRITE: begin
              cmd.write = 1'b1;
            end
            MODE_CLEAR: begin
              cmd.clear = 1'b1;
            end
            MODE_CHECK: begin
              cmd.start    = 1'b1;
              cmd.want_due = 1'b1;
              pass_due_nxt = 1'b1;
              state_nxt    = ST_SCAN;
            end
            // The unused mode code is accepted and dropped.
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // With nothing due, move on to the future pass at once.
        priority if (pass_due_r && !status.found) begin
          cmd.start    = 1'b1;
          cmd.want_due = 1'b0;
          pass_due_nxt = 1'b0;
          state_nxt    = ST_SCAN;
        end else if (status.out_free) begin
          if (pass_due_r) begin
            cmd.fire     = 1'b1;
            cmd.start    = 1'b1;
            cmd.want_due = 1'b1;
            state_nxt    = ST_SCAN;
          end else begin
            cmd.report = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else begin
          // The best event waits here until the output register frees up.
          state_nxt = ST_DECIDE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pass_due_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pass_due_r <= pass_due_nxt;
    end
  end

endmodule

>>> hdl/dtet_datapath.sv
// Datapath of the event table: slot RAM, valid bits, scan and best-event registers.
`timescale 1ns / 1ps
module dtet_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [3:0]        in_slot,
  input  logic [31:0]       in_timestamp,
  input  logic [7:0]        in_schedule,
  input  logic [7:0]        in_portion,
  input  logic [31:0]       now_time,
  input  dtet_pkg::cmd_t    cmd,
  output dtet_pkg::status_t status,
  dtet_out_if.source        out_chan
);
  import dtet_pkg::*;

  logic [EVENT_SLOTS-1:0] valid_r;
  logic [31:0]            now_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   want_due_r;
  logic                   found_r;
  logic [SLOT_IW-1:0]     best_idx_r;
  entry_t                 best_r;

  logic        out_valid_r;
  logic        out_kind_r;
  logic [7:0]  out_schedule_r;
  logic [7:0]  out_portion_r;
  logic [31:0] out_timestamp_r;
  logic        out_alarm_r;
  logic        out_last_r;

  logic               wr_ok;
  entry_t             wr_entry;
  entry_t             rd_entry;
  logic               rd_en;
  logic [CNT_W-1:0]   cnt_m1;
  logic [SLOT_IW-1:0] ev_idx;
  logic               ev_live;
  logic               ev_due;
  logic               ev_match;
  logic               ev_better;
  logic               out_free;

  assign wr_ok    = cmd.write && (32'(in_slot) < EVENT_SLOTS);
  assign wr_entry = '{stamp: in_timestamp, schedule: in_schedule, portion: in_portion};
  assign rd_en    = cmd.scan && (cnt_r < CNT_W'(EVENT_SLOTS));

  dtet_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (EVENT_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (SLOT_IW'(in_slot)),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (cnt_r[SLOT_IW-1:0]),
    .rdata (rd_entry)
  );

  // Read data is registered, so a count of k judges slot k-1.
  assign cnt_m1    = cnt_r - 1'b1;
  assign ev_idx    = cnt_m1[SLOT_IW-1:0];
  assign ev_live   = cmd.scan && (cnt_r != '0);
  assign ev_due    = (rd_entry.stamp <= now_r);
  assign ev_match  = ev_live && valid_r[ev_idx] && (ev_due == want_due_r);
  assign ev_better = !found_r || (rd_entry.stamp < best_r.stamp);

  assign out_free         = !out_valid_r || out_chan.ready;
  assign status.scan_done = cmd.scan && (cnt_r == CNT_W'(EVENT_SLOTS));
  assign status.found     = found_r;
  assign status.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd.clear) begin
        valid_r <= '0;
      end else if (wr_ok) begin
        valid_r[SLOT_IW'(in_slot)] <= 1'b1;
      end else if (cmd.fire) begin
        valid_r[best_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.start) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan) begin
      cnt_r <= cnt_r + 1'b1;
      if (ev_match && ev_better) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      want_due_r <= cmd.want_due;
    end
    if (cmd.start && cmd.want_due && !cmd.fire) begin
      now_r <= now_time;
    end
    if (ev_match && ev_better) begin
      best_idx_r <= ev_idx;
      best_r     <= rd_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fire || cmd.report) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      out_kind_r      <= KIND_FIRED;
      out_schedule_r  <= best_r.schedule;
      out_portion_r   <= best_r.portion;
      out_timestamp_r <= best_r.stamp;
      out_alarm_r     <= 1'b0;
      out_last_r      <= 1'b0;
    end else if (cmd.report) begin
      out_kind_r      <= KIND_REPORT;
      out_schedule_r  <= found_r ? best_r.schedule : 8'd0;
      out_portion_r   <= 8'd0;
      out_timestamp_r <= found_r ? best_r.stamp : 32'd0;
      out_alarm_r     <= found_r;
      out_last_r      <= 1'b1;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.kind          = out_kind_r;
  assign out_chan.out_schedule  = out_schedule_r;
  assign out_chan.out_portion   = out_portion_r;
  assign out_chan.out_timestamp = out_timestamp_r;
  assign out_chan.alarm_set     = out_alarm_r;
  assign out_chan.last          = out_last_r;

endmodule

>>> hdl/due_timer_event_table.sv
// Top level of the due timer event table: controller, datapath and checks.
// A write or clear takes effect at its accept edge and gives no result; a check
// runs one scan per fired event, one due scan that finds nothing and one for the report;
// each scan walks the slots one at a time through the slot RAM's single read port.
// Only one request is taken at a time; a check with F due events blocks requests for its
// F + 2 scans plus result stalls. Reset: sync, active low, clears valid bits and control state.
`timescale 1ns / 1ps
module due_timer_event_table (
  input  logic      clk,
  input  logic      rst_n,
  dtet_in_if.sink   in_chan,
  dtet_out_if.source out_chan
);
  import dtet_pkg::*;

  // Commands flow from the controller to the datapath; status flows back.
  cmd_t    cmd;
  status_t status;

  // The controller owns the request handshake and decides, at the end of each scan,
  // whether to fire the best due event, start the future pass, or send the report.
  dtet_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_mode  (in_chan.mode),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the slot RAM, walks it one slot a cycle, keeps the earliest
  // matching entry and owns the output register, so a finished result can wait
  // while the next scan runs.
  dtet_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_slot      (in_chan.slot),
    .in_timestamp (in_chan.in_timestamp),
    .in_schedule  (in_chan.in_schedule),
    .in_portion   (in_chan.in_portion),
    .now_time     (in_chan.now_time),
    .cmd          (cmd),
    .status       (status),
    .out_chan     (out_chan)
  );

`ifndef ASSERT_OFF
  // A check request keeps the request side busy in the following cycle.
  a_check_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && (in_chan.mode == MODE_CHECK) |=> !in_chan.ready)
    else $error("request accepted right after a check request");

  // A result is loaded only when the output register is free.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fire || cmd.report) |-> status.out_free)
    else $error("result loaded over a pending result");

  // A fired event never carries the alarm or end marks.
  a_fired_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.kind == KIND_FIRED) |-> !out_chan.alarm_set && !out_chan.last)
    else $error("fired result with alarm or last set");

  // A check ends with a report, after which the request side is open again.
  a_report_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.report |=> in_chan.ready)
    else $error("request side still busy after the report");
`endif

endmodule

>>> dv/dtet_fire_checker.sv
// Checker for the due timer event table: mirrors the slot table and compares every result.
`timescale 1ns / 1ps
module dtet_fire_checker (
  input  logic clk,
  input  logic rst_n,
  dtet_in_if   in_mon,
  dtet_out_if  out_mon,
  input  logic end_of_test,
  output int   errors,
  output int   pending
);
  import dtet_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [7:0]  schedule;
    logic [7:0]  portion;
    logic [31:0] stamp;
    logic        alarm;
    logic        last;
  } result_t;

  // Shadow copy of the event table.
  logic [31:0] ev_stamp  [EVENT_SLOTS];
  logic [7:0]  ev_sched  [EVENT_SLOTS];
  logic [7:0]  ev_portion[EVENT_SLOTS];
  bit          ev_armed  [EVENT_SLOTS];

  result_t due_results_q[$];
  int      result_idx;
  bit      eot_seen;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
    errors++;
  endtask

  // Earliest armed slot that is due (or strictly in the future), lowest slot on ties.
  function automatic int earliest_slot(input logic [31:0] now, input bit want_due);
    int best = -1;
    for (int i = 0; i < EVENT_SLOTS; i++) begin
      if (ev_armed[i] && ((ev_stamp[i] <= now) == want_due)) begin
        if (best < 0 || ev_stamp[i] < ev_stamp[best]) best = i;
      end
    end
    return best;
  endfunction

  // Queues the fired events of one check request, then its alarm report.
  task automatic predict_fired_events(input logic [31:0] now);
    int      idx;
    result_t r;
    idx = earliest_slot(now, 1'b1);
    while (idx >= 0) begin
      r.kind     = KIND_FIRED;
      r.schedule = ev_sched[idx];
      r.portion  = ev_portion[idx];
      r.stamp    = ev_stamp[idx];
      r.alarm    = 1'b0;
      r.last     = 1'b0;
      due_results_q.push_back(r);
      ev_armed[idx] = 1'b0;
      idx = earliest_slot(now, 1'b1);
    end
    idx = earliest_slot(now, 1'b0);
    r.kind    = KIND_REPORT;
    r.portion = 8'd0;
    r.last    = 1'b1;
    if (idx >= 0) begin
      r.schedule = ev_sched[idx];
      r.stamp    = ev_stamp[idx];
      r.alarm    = 1'b1;
    end else begin
      r.schedule = 8'd0;
      r.stamp    = 32'd0;
      r.alarm    = 1'b0;
    end
    due_results_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got 0x%0h, wanted 0x%0h",
                                result_idx, name, got, want));
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      for (int i = 0; i < EVENT_SLOTS; i++) ev_armed[i] = 1'b0;
      due_results_q.delete();
      result_idx = 0;
    end else begin
      // The request side is handled first so that the table is current.
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.mode)
          MODE_WRITE: begin
            if (int'(in_mon.slot) < EVENT_SLOTS) begin
              ev_stamp[in_mon.slot]   = in_mon.in_timestamp;
              ev_sched[in_mon.slot]   = in_mon.in_schedule;
              ev_portion[in_mon.slot] = in_mon.in_portion;
              ev_armed[in_mon.slot]   = 1'b1;
            end
          end
          MODE_CLEAR: begin
            for (int i = 0; i < EVENT_SLOTS; i++) ev_armed[i] = 1'b0;
          end
          MODE_CHECK: predict_fired_events(in_mon.now_time);
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (due_results_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", result_idx));
        end else begin
          want = due_results_q.pop_front();
          check_field("kind", 32'(out_mon.kind), 32'(want.kind));
          check_field("schedule", 32'(out_mon.out_schedule), 32'(want.schedule));
          check_field("portion", 32'(out_mon.out_portion), 32'(want.portion));
          check_field("timestamp", out_mon.out_timestamp, want.stamp);
          check_field("alarm_set", 32'(out_mon.alarm_set), 32'(want.alarm));
          check_field("last", 32'(out_mon.last), 32'(want.last));
        end
        result_idx++;
      end
      if (end_of_test && !eot_seen) begin
        eot_seen = 1'b1;
        if (due_results_q.size() != 0)
          report_mismatch($sformatf("%0d expected results never arrived",
                                    due_results_q.size()));
      end
    end
    pending = due_results_q.size();
  end

endmodule

>>> dv/due_timer_event_table_tb.sv
// Testbench top for the due timer event table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module due_timer_event_table_tb;
  import dtet_pkg::*;

  // The fourth mode code has no meaning; the block must ignore it.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Length of the one long receiver hold-off, in cycles. It is long enough that a
  // check with a full table backs up and the sender sits on a pending request.
  localparam int LONG_HOLD = 600;

  // Cycles allowed after the last result. The worst check is sixteen fired events,
  // one empty due scan and the report scan.
  localparam int TAIL_CYCLES = 400;
  localparam int DRAIN_LIMIT = 20000;

  localparam int ITEM_TARGET = 300;

  logic clk;
  logic rst_n;
  logic end_of_test;
  logic hold_req;
  logic no_idle;
  int   errors;
  int   pending;
  int   items_sent;

  // Time base that the random sequences move forward, so writes land near checks.
  logic [31:0] base_t;
  logic [31:0] last_ts;

  dtet_in_if  in_chan ();
  dtet_out_if out_chan ();

  due_timer_event_table i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  dtet_fire_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .end_of_test (end_of_test),
    .errors      (errors),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one request and returns after the edge that accepted it and any idle gap. When the
  // next request follows with no gap, valid simply stays high.
  task automatic offer(input logic [1:0] mode, input logic [3:0] slot,
                       input logic [31:0] ts, input logic [7:0] sched,
                       input logic [7:0] portion, input logic [31:0] now);
    int gap;
    in_chan.valid        <= 1'b1;
    in_chan.mode         <= mode;
    in_chan.slot         <= slot;
    in_chan.in_timestamp <= ts;
    in_chan.in_schedule  <= sched;
    in_chan.in_portion   <= portion;
    in_chan.now_time     <= now;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write request with random payload; the unused now_time field carries noise.
  task automatic write_event(input logic [3:0] slot, input logic [31:0] ts);
    offer(MODE_WRITE, slot, ts, 8'($urandom), 8'($urandom), $urandom);
  endtask

  task automatic check_at(input logic [31:0] now);
    offer(MODE_CHECK, 4'($urandom), $urandom, 8'($urandom), 8'($urandom), now);
  endtask

  task automatic clear_all();
    offer(MODE_CLEAR, 4'($urandom), $urandom, 8'($urandom), 8'($urandom), $urandom);
  endtask

  // Loads every slot near the time base, with some ties, then checks late enough
  // that the whole table fires: the largest number of results one request gives.
  task automatic fill_and_fire();
    logic [31:0] ts;
    for (int s = 0; s < EVENT_SLOTS; s++) begin
      ts = ($urandom_range(0, 3) == 0) ? last_ts : base_t + $urandom_range(0, 300);
      write_event(4'(s), ts);
      last_ts = ts;
    end
    check_at(base_t + 400);
    base_t = base_t + 500;
  endtask

  // A few writes around the time base followed by a check that fires some of them
  // and leaves others for the alarm report.
  task automatic burst_then_check();
    logic [31:0] ts;
    int n;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      ts = ($urandom_range(0, 3) == 0) ? last_ts : base_t + $urandom_range(0, 250);
      write_event(4'($urandom_range(0, 15)), ts);
      last_ts = ts;
    end
    check_at(base_t + $urandom_range(0, 150));
    base_t = base_t + $urandom_range(0, 120);
  endtask

  // Receiver. One assignment to ready per cycle. The long hold-off is counted here
  // while the stimulus keeps offering requests.
  initial begin : receiver
    int  stall_cnt;
    int  hold_cnt;
    bit  hold_done;
    bit  nxt;
    stall_cnt = 0;
    hold_cnt  = 0;
    hold_done = 1'b0;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        nxt = 1'b0;
        hold_cnt++;
        if (hold_cnt >= LONG_HOLD) hold_done = 1'b1;
      end else if (stall_cnt > 0) begin
        nxt = 1'b0;
        stall_cnt--;
      end else begin
        nxt = 1'b1;
        if (!no_idle && $urandom_range(0, 2) == 0) stall_cnt = pick_gap();
      end
      out_chan.ready <= nxt;
      @(posedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int roll;
    int seq;
    rst_n                <= 1'b0;
    end_of_test          <= 1'b0;
    hold_req             <= 1'b0;
    no_idle              <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.mode         <= MODE_WRITE;
    in_chan.slot         <= '0;
    in_chan.in_timestamp <= '0;
    in_chan.in_schedule  <= '0;
    in_chan.in_portion   <= '0;
    in_chan.now_time     <= '0;
    items_sent = 0;
    base_t     = $urandom;
    last_ts    = base_t;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. An empty table reports a disabled alarm.
    check_at(32'd0);
    // Extreme payloads at the lowest and highest slot and time.
    offer(MODE_WRITE, 4'd0, 32'd0, 8'h00, 8'h00, 32'hFFFF_FFFF);
    offer(MODE_WRITE, 4'd15, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'd0);
    // An event stamped exactly at the current time is due.
    check_at(32'd0);
    check_at(32'hFFFF_FFFF);
    // Equal timestamps must fire in slot order; 101 is the first future event.
    write_event(4'd3, 32'd100);
    write_event(4'd7, 32'd100);
    write_event(4'd9, 32'd100);
    write_event(4'd5, 32'd50);
    write_event(4'd2, 32'd200);
    write_event(4'd4, 32'd101);
    // The unused mode must change nothing.
    offer(MODE_UNUSED, 4'($urandom), $urandom, 8'($urandom), 8'($urandom), 32'd100);
    check_at(32'd100);
    // Overwriting an armed slot replaces its event.
    write_event(4'd2, 32'd99);
    check_at(32'd100);
    // A clear disarms everything that is left.
    clear_all();
    check_at(32'hFFFF_FFFF);
    // Nothing due, one future event in the report.
    write_event(4'd8, 32'd1);
    check_at(32'd0);

    // Random part. It opens with a full table while the receiver holds off, so the
    // result side backs up and the block stalls its request input.
    hold_req <= 1'b1;
    fill_and_fire();
    seq = 0;
    while (items_sent < ITEM_TARGET) begin
      // One stretch runs with no idling on either side.
      no_idle <= (seq >= 20 && seq < 32);
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        burst_then_check();
      end else if (roll < 73) begin
        fill_and_fire();
      end else if (roll < 80) begin
        clear_all();
      end else if (roll < 85) begin
        offer(MODE_UNUSED, 4'($urandom), $urandom, 8'($urandom), 8'($urandom), $urandom);
      end else if (roll < 93) begin
        // Timestamps over the full 32-bit range, far from the time base.
        write_event(4'($urandom_range(0, 15)), $urandom);
      end else begin
        check_at($urandom);
      end
      seq++;
    end
    in_chan.valid <= 1'b0;
    no_idle       <= 1'b1;

    // Wait for the outstanding results, then give the block time to show anything extra.
    @(posedge clk);
    for (int w = 0; w < DRAIN_LIMIT && pending != 0; w++) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    end_of_test <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #4_000_000;
    $display("Timeout: the run did not complete");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
